FILE: hdl/cpcr_pkg.sv
// cpcr_pkg: word formats, chain lengths and constants for the circle pair resolver
// no dependencies
package cpcr_pkg;

   localparam int FRAC_BITS = 8;
   localparam int POS_W     = 24;
   localparam int RAD_W     = 16;
   localparam int MAG_W     = 17;
   localparam int ROOT_W    = 17;
   localparam int SQ_STEPS  = ROOT_W;
   localparam int N_W       = 2 * ROOT_W;
   localparam int REM_W     = ROOT_W + 1;
   localparam int DEN_W     = ROOT_W + 1;
   localparam int Q_W       = 17;
   localparam int DIV_STEPS = Q_W;
   localparam int PROD_W    = 2 * MAG_W;
   localparam int NUM_W     = PROD_W + 1;
   localparam int DSQ_W     = 2 * POS_W + 1;

   // squared-distance floor: dsq * 10000 > 2^(2*frac) is dsq > this
   localparam longint unsigned FLOOR_SQ = (64'd1 << (2 * FRAC_BITS)) / 64'd10000;

   typedef struct packed {
      logic signed [POS_W-1:0] ax;
      logic signed [POS_W-1:0] ay;
      logic signed [POS_W-1:0] bx;
      logic signed [POS_W-1:0] by;
      logic signed [POS_W-1:0] avx;
      logic signed [POS_W-1:0] avy;
      logic signed [POS_W-1:0] bvx;
      logic signed [POS_W-1:0] bvy;
      logic                    moving;
      logic                    hit;
      logic                    sx;
      logic                    sy;
      logic [MAG_W-1:0]        ux;
      logic [MAG_W-1:0]        uy;
      logic [MAG_W-1:0]        m;
   } pl_type;

   typedef struct packed {
      pl_type            pl;
      logic [N_W-1:0]    n;
      logic [REM_W-1:0]  rem;
      logic [ROOT_W-1:0] root;
   } sq_type;

   typedef struct packed {
      pl_type            pl;
      logic [DEN_W-1:0]  den;
      logic [Q_W-1:0]    nlo_x;
      logic [Q_W-1:0]    nlo_y;
      logic [DEN_W-1:0]  rem_x;
      logic [DEN_W-1:0]  rem_y;
      logic [Q_W-1:0]    q_x;
      logic [Q_W-1:0]    q_y;
   } dv_type;

endpackage

FILE: hdl/cpcr_sqrt_cell.sv
// cpcr_sqrt_cell: one digit of the integer square root, registered
// depends on cpcr_pkg
module cpcr_sqrt_cell (
   input  logic            clock,
   input  logic            reset,
   input  logic            en,
   input  logic            in_valid,
   input  cpcr_pkg::sq_type in_data,
   output logic            out_valid,
   output cpcr_pkg::sq_type out_data
);

   logic             valid_ff;
   cpcr_pkg::sq_type data_ff;
   cpcr_pkg::sq_type data_in;
   logic [cpcr_pkg::REM_W+1:0] r2;
   logic [cpcr_pkg::REM_W+1:0] trial;

   always_comb begin
      r2    = {in_data.rem, in_data.n[cpcr_pkg::N_W-1 -: 2]};
      trial = {1'b0, in_data.root, 2'b01};
      data_in      = in_data;
      data_in.n    = {in_data.n[cpcr_pkg::N_W-3:0], 2'b00};
      if (r2 >= trial) begin
         data_in.rem  = cpcr_pkg::REM_W'(r2 - trial);
         data_in.root = {in_data.root[cpcr_pkg::ROOT_W-2:0], 1'b1};
      end else begin
         data_in.rem  = cpcr_pkg::REM_W'(r2);
         data_in.root = {in_data.root[cpcr_pkg::ROOT_W-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

FILE: hdl/cpcr_div_cell.sv
// cpcr_div_cell: one quotient bit of both push divisions, registered
// depends on cpcr_pkg
module cpcr_div_cell (
   input  logic            clock,
   input  logic            reset,
   input  logic            en,
   input  logic            in_valid,
   input  cpcr_pkg::dv_type in_data,
   output logic            out_valid,
   output cpcr_pkg::dv_type out_data
);

   logic             valid_ff;
   cpcr_pkg::dv_type data_ff;
   cpcr_pkg::dv_type data_in;
   logic [cpcr_pkg::DEN_W:0] rx;
   logic [cpcr_pkg::DEN_W:0] ry;
   logic [cpcr_pkg::DEN_W:0] dd;

   always_comb begin
      rx = {in_data.rem_x, in_data.nlo_x[cpcr_pkg::Q_W-1]};
      ry = {in_data.rem_y, in_data.nlo_y[cpcr_pkg::Q_W-1]};
      dd = {1'b0, in_data.den};
      data_in       = in_data;
      data_in.nlo_x = {in_data.nlo_x[cpcr_pkg::Q_W-2:0], 1'b0};
      data_in.nlo_y = {in_data.nlo_y[cpcr_pkg::Q_W-2:0], 1'b0};
      if (rx >= dd) begin
         data_in.rem_x = cpcr_pkg::DEN_W'(rx - dd);
         data_in.q_x   = {in_data.q_x[cpcr_pkg::Q_W-2:0], 1'b1};
      end else begin
         data_in.rem_x = cpcr_pkg::DEN_W'(rx);
         data_in.q_x   = {in_data.q_x[cpcr_pkg::Q_W-2:0], 1'b0};
      end
      if (ry >= dd) begin
         data_in.rem_y = cpcr_pkg::DEN_W'(ry - dd);
         data_in.q_y   = {in_data.q_y[cpcr_pkg::Q_W-2:0], 1'b1};
      end else begin
         data_in.rem_y = cpcr_pkg::DEN_W'(ry);
         data_in.q_y   = {in_data.q_y[cpcr_pkg::Q_W-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

FILE: hdl/circle_pair_collision_resolve.sv
// circle_pair_collision_resolve: top level, overlap test, root and division cell chains
// depends on cpcr_pkg, cpcr_sqrt_cell, cpcr_div_cell
//
//   channel | ports            | word
//   input   | req_valid/ready  | two centres, two radii, two velocities, both_moving
//   result  | rsp_valid/ready  | corrected centres, velocities, overlapped
//
// one word enters per cycle while the pipeline is not stalled; a word passes through the setup
// stages, 17 root cells, the product stage, 17 division cells and the output register
// the whole pipeline advances together when the output register is empty or taken
// a stall on rsp_ready holds every stage and drops req_ready in the same cycle
// synchronous reset clears all valid flags; payload registers are not reset
module circle_pair_collision_resolve (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic signed [23:0] req_a_pos_x,
   input  logic signed [23:0] req_a_pos_y,
   input  logic signed [23:0] req_b_pos_x,
   input  logic signed [23:0] req_b_pos_y,
   input  logic [15:0] req_a_rad,
   input  logic [15:0] req_b_rad,
   input  logic signed [23:0] req_a_vel_x,
   input  logic signed [23:0] req_a_vel_y,
   input  logic signed [23:0] req_b_vel_x,
   input  logic signed [23:0] req_b_vel_y,
   input  logic        req_both_moving,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic signed [23:0] rsp_new_a_x,
   output logic signed [23:0] rsp_new_a_y,
   output logic signed [23:0] rsp_new_b_x,
   output logic signed [23:0] rsp_new_b_y,
   output logic signed [23:0] rsp_new_a_vx,
   output logic signed [23:0] rsp_new_a_vy,
   output logic signed [23:0] rsp_new_b_vx,
   output logic signed [23:0] rsp_new_b_vy,
   output logic        rsp_overlapped
);

   localparam int PW = cpcr_pkg::POS_W;

   function automatic logic signed [PW-1:0] sat_pos(input logic signed [PW+1:0] v);
      logic signed [PW+1:0] hi;
      logic signed [PW+1:0] lo;
      hi = (PW+2)'((1 << (PW-1)) - 1);
      lo = -hi - (PW+2)'(1);
      if (v > hi) begin
         return PW'(hi);
      end else if (v < lo) begin
         return PW'(lo);
      end else begin
         return PW'(v);
      end
   endfunction

   logic en;

   // setup stage 0
   logic                  s0_v_ff;
   cpcr_pkg::pl_type      s0_pl_ff, s0_pl_in;
   logic [PW-1:0]         s0_ux_ff, s0_uy_ff, s0_ux_in, s0_uy_in;
   logic signed [PW:0]    dx, dy;

   // setup stage 1
   logic                  s1_v_ff;
   cpcr_pkg::pl_type      s1_pl_ff;
   logic [2*PW-1:0]       s1_sqx_ff, s1_sqy_ff;
   logic [cpcr_pkg::N_W-1:0] s1_mm_ff;

   logic [cpcr_pkg::DSQ_W-1:0] dsq;
   logic                  hit;

   logic                  sq_v [0:cpcr_pkg::SQ_STEPS];
   cpcr_pkg::sq_type      sq_d [0:cpcr_pkg::SQ_STEPS];
   logic                  sq_v0_ff;
   cpcr_pkg::sq_type      sq_d0_ff, sq_d0_in;

   // product stage
   logic                  s3_v_ff;
   cpcr_pkg::pl_type      s3_pl_ff;
   logic [cpcr_pkg::ROOT_W-1:0] s3_dist_ff;
   logic [cpcr_pkg::PROD_W-1:0] s3_px_ff, s3_py_ff;
   logic [cpcr_pkg::MAG_W-1:0]  ov;
   logic [cpcr_pkg::ROOT_W-1:0] sq_root;

   logic                  dv_v [0:cpcr_pkg::DIV_STEPS];
   cpcr_pkg::dv_type      dv_d [0:cpcr_pkg::DIV_STEPS];
   logic                  dv_v0_ff;
   cpcr_pkg::dv_type      dv_d0_ff, dv_d0_in;
   logic [cpcr_pkg::NUM_W-1:0] nx, ny;

   // output stage
   logic                  out_v_ff;
   cpcr_pkg::pl_type      fin;
   logic signed [PW+1:0]  px, py;
   logic signed [PW-1:0]  o_ax_ff, o_ay_ff, o_bx_ff, o_by_ff;
   logic signed [PW-1:0]  o_avx_ff, o_avy_ff, o_bvx_ff, o_bvy_ff;
   logic signed [PW-1:0]  o_ax_in, o_ay_in, o_bx_in, o_by_in;
   logic signed [PW-1:0]  o_avx_in, o_avy_in, o_bvx_in, o_bvy_in;
   logic                  o_hit_ff;

   assign en        = ~out_v_ff | rsp_ready;
   assign req_ready = en;

   // stage 0: differences and magnitudes
   always_comb begin
      dx = (PW+1)'(req_b_pos_x) - (PW+1)'(req_a_pos_x);
      dy = (PW+1)'(req_b_pos_y) - (PW+1)'(req_a_pos_y);
      s0_ux_in = dx[PW] ? PW'(-dx) : PW'(dx);
      s0_uy_in = dy[PW] ? PW'(-dy) : PW'(dy);
      s0_pl_in.ax     = req_a_pos_x;
      s0_pl_in.ay     = req_a_pos_y;
      s0_pl_in.bx     = req_b_pos_x;
      s0_pl_in.by     = req_b_pos_y;
      s0_pl_in.avx    = req_a_vel_x;
      s0_pl_in.avy    = req_a_vel_y;
      s0_pl_in.bvx    = req_b_vel_x;
      s0_pl_in.bvy    = req_b_vel_y;
      s0_pl_in.moving = req_both_moving;
      s0_pl_in.hit    = 1'b0;
      s0_pl_in.sx     = dx[PW];
      s0_pl_in.sy     = dy[PW];
      s0_pl_in.ux     = cpcr_pkg::MAG_W'(s0_ux_in);
      s0_pl_in.uy     = cpcr_pkg::MAG_W'(s0_uy_in);
      s0_pl_in.m      = cpcr_pkg::MAG_W'(req_a_rad) + cpcr_pkg::MAG_W'(req_b_rad);
   end

   // stage 2: squared distance and overlap test
   always_comb begin
      dsq = cpcr_pkg::DSQ_W'(s1_sqx_ff) + cpcr_pkg::DSQ_W'(s1_sqy_ff);
      hit = (dsq < cpcr_pkg::DSQ_W'(s1_mm_ff)) &&
            (dsq > cpcr_pkg::DSQ_W'(cpcr_pkg::FLOOR_SQ));
      sq_d0_in.pl     = s1_pl_ff;
      sq_d0_in.pl.hit = hit;
      sq_d0_in.n      = hit ? cpcr_pkg::N_W'(dsq) : '0;
      sq_d0_in.rem    = '0;
      sq_d0_in.root   = '0;
   end

   // product stage: overlap and numerators
   always_comb begin
      sq_root = sq_d[cpcr_pkg::SQ_STEPS].root;
      ov      = sq_d[cpcr_pkg::SQ_STEPS].pl.m - cpcr_pkg::MAG_W'(sq_root);
   end

   // division set-up: add rounding term and align remainders
   always_comb begin
      nx = cpcr_pkg::NUM_W'(s3_px_ff) + cpcr_pkg::NUM_W'(s3_dist_ff);
      ny = cpcr_pkg::NUM_W'(s3_py_ff) + cpcr_pkg::NUM_W'(s3_dist_ff);
      dv_d0_in.pl    = s3_pl_ff;
      dv_d0_in.den   = {s3_dist_ff, 1'b0};
      dv_d0_in.rem_x = nx[cpcr_pkg::NUM_W-1 -: cpcr_pkg::DEN_W];
      dv_d0_in.rem_y = ny[cpcr_pkg::NUM_W-1 -: cpcr_pkg::DEN_W];
      dv_d0_in.nlo_x = nx[cpcr_pkg::Q_W-1:0];
      dv_d0_in.nlo_y = ny[cpcr_pkg::Q_W-1:0];
      dv_d0_in.q_x   = '0;
      dv_d0_in.q_y   = '0;
   end

   // output stage: on overlap apply push, saturate, and swap velocities if both moving
   always_comb begin
      fin = dv_d[cpcr_pkg::DIV_STEPS].pl;
      px  = fin.sx ? -(PW+2)'(dv_d[cpcr_pkg::DIV_STEPS].q_x)
                   :  (PW+2)'(dv_d[cpcr_pkg::DIV_STEPS].q_x);
      py  = fin.sy ? -(PW+2)'(dv_d[cpcr_pkg::DIV_STEPS].q_y)
                   :  (PW+2)'(dv_d[cpcr_pkg::DIV_STEPS].q_y);
      o_ax_in  = fin.ax;
      o_ay_in  = fin.ay;
      o_bx_in  = fin.bx;
      o_by_in  = fin.by;
      o_avx_in = fin.avx;
      o_avy_in = fin.avy;
      o_bvx_in = fin.bvx;
      o_bvy_in = fin.bvy;
      if (fin.hit) begin
         o_ax_in = sat_pos((PW+2)'(fin.ax) - px);
         o_ay_in = sat_pos((PW+2)'(fin.ay) - py);
         o_bx_in = sat_pos((PW+2)'(fin.bx) + px);
         o_by_in = sat_pos((PW+2)'(fin.by) + py);
         if (fin.moving) begin
            o_avx_in = fin.bvx;
            o_avy_in = fin.bvy;
            o_bvx_in = fin.avx;
            o_bvy_in = fin.avy;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_v_ff  <= 1'b0;
         s1_v_ff  <= 1'b0;
         sq_v0_ff <= 1'b0;
         s3_v_ff  <= 1'b0;
         dv_v0_ff <= 1'b0;
         out_v_ff <= 1'b0;
      end else if (en) begin
         s0_v_ff  <= req_valid;
         s1_v_ff  <= s0_v_ff;
         sq_v0_ff <= s1_v_ff;
         s3_v_ff  <= sq_v[cpcr_pkg::SQ_STEPS];
         dv_v0_ff <= s3_v_ff;
         out_v_ff <= dv_v[cpcr_pkg::DIV_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s0_pl_ff   <= s0_pl_in;
         s0_ux_ff   <= s0_ux_in;
         s0_uy_ff   <= s0_uy_in;
         s1_pl_ff   <= s0_pl_ff;
         s1_sqx_ff  <= s0_ux_ff * s0_ux_ff;
         s1_sqy_ff  <= s0_uy_ff * s0_uy_ff;
         s1_mm_ff   <= cpcr_pkg::N_W'(s0_pl_ff.m) * cpcr_pkg::N_W'(s0_pl_ff.m);
         sq_d0_ff   <= sq_d0_in;
         s3_pl_ff   <= sq_d[cpcr_pkg::SQ_STEPS].pl;
         s3_dist_ff <= sq_root;
         s3_px_ff   <= cpcr_pkg::PROD_W'(sq_d[cpcr_pkg::SQ_STEPS].pl.ux) *
                       cpcr_pkg::PROD_W'(ov);
         s3_py_ff   <= cpcr_pkg::PROD_W'(sq_d[cpcr_pkg::SQ_STEPS].pl.uy) *
                       cpcr_pkg::PROD_W'(ov);
         dv_d0_ff   <= dv_d0_in;
         o_ax_ff    <= o_ax_in;
         o_ay_ff    <= o_ay_in;
         o_bx_ff    <= o_bx_in;
         o_by_ff    <= o_by_in;
         o_avx_ff   <= o_avx_in;
         o_avy_ff   <= o_avy_in;
         o_bvx_ff   <= o_bvx_in;
         o_bvy_ff   <= o_bvy_in;
         o_hit_ff   <= fin.hit;
      end
   end

   assign sq_v[0] = sq_v0_ff;
   assign sq_d[0] = sq_d0_ff;
   assign dv_v[0] = dv_v0_ff;
   assign dv_d[0] = dv_d0_ff;

   for (genvar i = 0; i < cpcr_pkg::SQ_STEPS; i++) begin : g_sqrt
      cpcr_sqrt_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .in_valid  (sq_v[i]),
         .in_data   (sq_d[i]),
         .out_valid (sq_v[i+1]),
         .out_data  (sq_d[i+1])
      );
   end

   for (genvar i = 0; i < cpcr_pkg::DIV_STEPS; i++) begin : g_div
      cpcr_div_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .in_valid  (dv_v[i]),
         .in_data   (dv_d[i]),
         .out_valid (dv_v[i+1]),
         .out_data  (dv_d[i+1])
      );
   end

   assign rsp_valid      = out_v_ff;
   assign rsp_new_a_x    = o_ax_ff;
   assign rsp_new_a_y    = o_ay_ff;
   assign rsp_new_b_x    = o_bx_ff;
   assign rsp_new_b_y    = o_by_ff;
   assign rsp_new_a_vx   = o_avx_ff;
   assign rsp_new_a_vy   = o_avy_ff;
   assign rsp_new_b_vx   = o_bvx_ff;
   assign rsp_new_b_vy   = o_bvy_ff;
   assign rsp_overlapped = o_hit_ff;

   a_root_below_sum: assert property (@(posedge clock) disable iff (reset)
      sq_v[cpcr_pkg::SQ_STEPS] && sq_d[cpcr_pkg::SQ_STEPS].pl.hit |->
      sq_d[cpcr_pkg::SQ_STEPS].root < sq_d[cpcr_pkg::SQ_STEPS].pl.m)
      else $error("root not below radius sum");

   a_divisor_nonzero: assert property (@(posedge clock) disable iff (reset)
      dv_v[0] && dv_d[0].pl.hit |-> dv_d[0].den != '0)
      else $error("zero divisor on overlapping pair");

   a_push_bounded: assert property (@(posedge clock) disable iff (reset)
      dv_v[cpcr_pkg::DIV_STEPS] && fin.hit |->
      !dv_d[cpcr_pkg::DIV_STEPS].q_x[cpcr_pkg::Q_W-1] &&
      !dv_d[cpcr_pkg::DIV_STEPS].q_y[cpcr_pkg::Q_W-1])
      else $error("push exceeds half the overlap range");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

endmodule
